// ===== rtl/dxt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, format codes and constant-divide helpers for the DXT block decoder.
// No dependencies; every rtl file uses it through scoped names.

package dxt_pkg;

    // Format codes of the block_format register (code 3 decodes as DXT1)
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam int          CNT_W     = 4;
    localparam logic [3:0]  LAST_TEXEL = 4'hF;

    // Reciprocals for truncating divides by constants (checked over each input range)
    localparam logic [13:0] RECIP31 = 14'd8457;   // x/31 = x*8457 >> 18, x <= 7905
    localparam logic [14:0] RECIP63 = 15'd16645;  // x/63 = x*16645 >> 20, x <= 16065
    localparam logic [9:0]  RECIP3  = 10'd683;    // x/3  = x*683 >> 11, x <= 765
    localparam logic [11:0] RECIP7  = 12'd2341;   // x/7  = x*2341 >> 14, x <= 1785
    localparam logic [10:0] RECIP5  = 11'd1639;   // x/5  = x*1639 >> 13, x <= 1275

    // Channel triple, index 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] rgb_t;

    // Accepted input word plus the format it decodes under
    typedef struct packed {
        logic [63:0] alpha_block;
        logic [63:0] color_block;
        logic [1:0]  fmt;
    } blk_t;

    // Expanded endpoints
    typedef struct packed {
        rgb_t        e0;
        rgb_t        e1;
        logic        four_color;
        logic [1:0]  fmt;
        logic [63:0] alpha_block;
        logic [31:0] cidx;
    } endp_t;

    // Complete per-block palettes
    typedef struct packed {
        rgb_t [3:0]      cpal;
        logic            four_color;
        logic [7:0][7:0] apal;
        logic [1:0]      fmt;
        logic [63:0]     alpha_block;
        logic [31:0]     cidx;
    } pal_t;

    // 5-bit channel to 8 bits: c*255/31, truncated
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [12:0] x;
        logic [26:0] p;
        x = {c, 8'd0} - 13'(c);
        p = 27'(x) * 27'(RECIP31);
        return p[25:18];
    endfunction

    // 6-bit channel to 8 bits: c*255/63, truncated
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [13:0] x;
        logic [28:0] p;
        x = {c, 8'd0} - 14'(c);
        p = 29'(x) * 29'(RECIP63);
        return p[27:20];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'(RECIP3);
        return p[18:11];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'(RECIP7);
        return p[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'(RECIP5);
        return p[20:13];
    endfunction

endpackage

// ===== rtl/dxt_block_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the DXT1/DXT3/DXT5 block decoder: input register, format register, stages.
// Depends on dxt_pkg, dxtb_endpoint, dxtb_palette and dxtb_texel_out.

// Each accepted word is one compressed 4x4 block; the decoder returns its sixteen RGBA8
// texels in raster order, one word per cycle while m_axis_tready is high, with tlast on
// the sixteenth; the texel counter fills the one-texel-wide output register, and a new
// block enters the palette stage only as the last texel of the held one is loaded. A
// block passes through the input register, endpoint stage and palette stage into the
// output register. Up to two further blocks are buffered in the stages behind the block
// being emitted, so the input takes up to two words while texels drain. block_format is
// sampled when a block is accepted; write it only while the decoder is idle.

module dxt_block_decoder (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,   // block_format
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // alpha_block[63:0], color_block[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // red, green, blue, alpha, texel_index, 4'b0 pad
    output logic         m_axis_tlast   // last_texel
);

    logic           alpha_fmt;
    logic [1:0]     block_format_reg;
    logic           in_valid_reg;
    dxt_pkg::blk_t  blk_reg;
    logic           blk_ready;
    logic           endp_valid;
    dxt_pkg::endp_t endp;
    logic           endp_ready;
    logic           pal_valid;
    dxt_pkg::pal_t  pal;
    logic           pal_done;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic [7:0]     alpha;
    logic [3:0]     texel_index;

    // Format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_format_reg <= dxt_pkg::FMT_DXT1;
        end
        else if (cfg_wr_en)
        begin
            block_format_reg <= cfg_wr_data;
        end
    end

    // Input register
    assign s_axis_tready = !in_valid_reg || blk_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            blk_reg.alpha_block <= s_axis_tdata[63:0];
            blk_reg.color_block <= s_axis_tdata[127:64];
            blk_reg.fmt         <= block_format_reg;
        end
    end

    dxtb_endpoint u_endpoint (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_valid  (in_valid_reg),
        .blk        (blk_reg),
        .blk_ready  (blk_ready),
        .endp_valid (endp_valid),
        .endp       (endp),
        .endp_ready (endp_ready)
    );

    dxtb_palette u_palette (
        .clk        (clk),
        .rst_n      (rst_n),
        .endp_valid (endp_valid),
        .endp       (endp),
        .endp_ready (endp_ready),
        .pal_valid  (pal_valid),
        .pal        (pal),
        .pal_done   (pal_done)
    );

    dxtb_texel_out u_texel_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .pal_valid   (pal_valid),
        .pal         (pal),
        .pal_done    (pal_done),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .texel_index (texel_index),
        .last_texel  (m_axis_tlast)
    );

    // Pack the output word
    assign m_axis_tdata = {4'd0, texel_index, alpha, blue, green, red};

    // Flag a format that carries its own alpha (DXT3 or DXT5)
    assign alpha_fmt = (block_format_reg == dxt_pkg::FMT_DXT3) ||
                       (block_format_reg == dxt_pkg::FMT_DXT5);

    // Accepted blocks always carry the format that was configured
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
            (blk_reg.fmt == $past(block_format_reg)))
        else $error("input register lost the sampled format");

    // Explicit or interpolated alpha formats never take the three-color path
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && alpha_fmt) |=> ##1
            (!endp_valid || endp.four_color))
        else $error("three-color palette chosen for an alpha format");

    // The input side is blocked only while the input register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && !blk_ready))
        else $error("input stalled with an empty input register");

endmodule

// ===== rtl/dxtb_endpoint.sv =====
`timescale 1ns / 1ps
// Endpoint stage: expands the two 565 color endpoints and picks the palette mode.
// Depends on dxt_pkg.

module dxtb_endpoint (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           blk_valid,
    input  dxt_pkg::blk_t  blk,
    output logic           blk_ready,
    output logic           endp_valid,
    output dxt_pkg::endp_t endp,
    input  logic           endp_ready
);

    logic           endp_valid_reg;
    dxt_pkg::endp_t endp_reg;
    dxt_pkg::endp_t endp_next;
    logic [15:0]    c0;
    logic [15:0]    c1;

    assign blk_ready = !endp_valid_reg || endp_ready;

    // Expand endpoints; DXT1 drops to three colors when c0 <= c1
    always_comb
    begin
        c0 = blk.color_block[15:0];
        c1 = blk.color_block[31:16];
        endp_next.e0[0]      = dxt_pkg::expand5(c0[15:11]);
        endp_next.e0[1]      = dxt_pkg::expand6(c0[10:5]);
        endp_next.e0[2]      = dxt_pkg::expand5(c0[4:0]);
        endp_next.e1[0]      = dxt_pkg::expand5(c1[15:11]);
        endp_next.e1[1]      = dxt_pkg::expand6(c1[10:5]);
        endp_next.e1[2]      = dxt_pkg::expand5(c1[4:0]);
        endp_next.four_color = (blk.fmt == dxt_pkg::FMT_DXT3) ||
                               (blk.fmt == dxt_pkg::FMT_DXT5) || (c0 > c1);
        endp_next.fmt         = blk.fmt;
        endp_next.alpha_block = blk.alpha_block;
        endp_next.cidx        = blk.color_block[63:32];
    end

    // Hold valid until the palette stage takes the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            endp_valid_reg <= 1'b0;
        end
        else if (blk_ready)
        begin
            endp_valid_reg <= blk_valid;
        end
    end

    // Load payload on advance
    always_ff @(posedge clk)
    begin
        if (blk_ready && blk_valid)
        begin
            endp_reg <= endp_next;
        end
    end

    assign endp_valid = endp_valid_reg;
    assign endp       = endp_reg;

endmodule

// ===== rtl/dxtb_palette.sv =====
`timescale 1ns / 1ps
// Palette stage: builds the four-entry color palette and eight-entry alpha palette.
// Depends on dxt_pkg; holds the block until its sixteenth texel is loaded into the output register.

module dxtb_palette (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           endp_valid,
    input  dxt_pkg::endp_t endp,
    output logic           endp_ready,
    output logic           pal_valid,
    output dxt_pkg::pal_t  pal,
    input  logic           pal_done
);

    logic               pal_valid_reg;
    dxt_pkg::pal_t      pal_reg;
    dxt_pkg::pal_t      pal_next;
    logic [7:0]         a0;
    logic [7:0]         a1;
    logic [6:1][7:0]    lerp7;
    logic [4:1][7:0]    lerp5;
    logic [2:0][7:0]    third0;
    logic [2:0][7:0]    third1;
    logic [2:0][7:0]    half;

    assign a0 = endp.alpha_block[7:0];
    assign a1 = endp.alpha_block[15:8];

    // Interpolate alpha in sevenths and fifths
    for (genvar gi = 1; gi < 7; gi++)
    begin : g_lerp7
        assign lerp7[gi] = dxt_pkg::div7(11'(7 - gi) * 11'(a0) + 11'(gi) * 11'(a1));
    end

    for (genvar gi = 1; gi < 5; gi++)
    begin : g_lerp5
        assign lerp5[gi] = dxt_pkg::div5(11'(5 - gi) * 11'(a0) + 11'(gi) * 11'(a1));
    end

    // Mix color channels in thirds and halves
    for (genvar gk = 0; gk < 3; gk++)
    begin : g_mix
        logic [8:0] sum2;
        assign third0[gk] = dxt_pkg::div3(10'({endp.e0[gk], 1'b0}) + 10'(endp.e1[gk]));
        assign third1[gk] = dxt_pkg::div3(10'(endp.e0[gk]) + 10'({endp.e1[gk], 1'b0}));
        assign sum2       = 9'(endp.e0[gk]) + 9'(endp.e1[gk]);
        assign half[gk]   = sum2[8:1];
    end

    // Assemble palettes
    always_comb
    begin
        pal_next.cpal[0] = endp.e0;
        pal_next.cpal[1] = endp.e1;
        if (endp.four_color)
        begin
            pal_next.cpal[2] = third0;
            pal_next.cpal[3] = third1;
        end
        else
        begin
            pal_next.cpal[2] = half;
            pal_next.cpal[3] = '0;
        end

        pal_next.apal[0] = a0;
        pal_next.apal[1] = a1;
        if (a0 > a1)
        begin
            pal_next.apal[2] = lerp7[1];
            pal_next.apal[3] = lerp7[2];
            pal_next.apal[4] = lerp7[3];
            pal_next.apal[5] = lerp7[4];
            pal_next.apal[6] = lerp7[5];
            pal_next.apal[7] = lerp7[6];
        end
        else
        begin
            pal_next.apal[2] = lerp5[1];
            pal_next.apal[3] = lerp5[2];
            pal_next.apal[4] = lerp5[3];
            pal_next.apal[5] = lerp5[4];
            pal_next.apal[6] = 8'h00;
            pal_next.apal[7] = 8'hFF;
        end

        pal_next.four_color  = endp.four_color;
        pal_next.fmt         = endp.fmt;
        pal_next.alpha_block = endp.alpha_block;
        pal_next.cidx        = endp.cidx;
    end

    // Free the stage when the last texel is loaded into the output register
    assign endp_ready = !pal_valid_reg || pal_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= 1'b0;
        end
        else if (endp_ready)
        begin
            pal_valid_reg <= endp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (endp_ready && endp_valid)
        begin
            pal_reg <= pal_next;
        end
    end

    assign pal_valid = pal_valid_reg;
    assign pal       = pal_reg;

endmodule

// ===== rtl/dxtb_texel_out.sv =====
`timescale 1ns / 1ps
// Texel stage: walks the sixteen texels of the held block into the output register.
// Depends on dxt_pkg.

module dxtb_texel_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pal_valid,
    input  dxt_pkg::pal_t pal,
    output logic          pal_done,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue,
    output logic [7:0]    alpha,
    output logic [3:0]    texel_index,
    output logic          last_texel
);

    logic [dxt_pkg::CNT_W-1:0] cnt_reg;
    logic                      out_valid_reg;
    logic                      out_load;
    logic [1:0]                ci;
    logic [3:0]                nib;
    logic [5:0]                abase;
    logic [2:0]                ai;
    logic [7:0]                alpha_next;
    logic [7:0]                red_reg;
    logic [7:0]                green_reg;
    logic [7:0]                blue_reg;
    logic [7:0]                alpha_reg;
    logic [3:0]                index_reg;
    logic                      last_reg;

    // Advance one texel whenever a palette is held and the output register is free or being taken
    assign out_load = pal_valid && (!out_valid_reg || out_ready);
    assign pal_done = out_load && (cnt_reg == dxt_pkg::LAST_TEXEL);

    // Select palette entries for the current texel
    always_comb
    begin
        ci    = pal.cidx[{cnt_reg, 1'b0} +: 2];
        nib   = pal.alpha_block[{cnt_reg, 2'b00} +: 4];
        abase = 6'd16 + 6'(cnt_reg) * 6'd3;
        ai    = pal.alpha_block[abase +: 3];
        case (pal.fmt)
            dxt_pkg::FMT_DXT3:
            begin
                alpha_next = {nib, nib};
            end
            dxt_pkg::FMT_DXT5:
            begin
                alpha_next = pal.apal[ai];
            end
            default:
            begin
                alpha_next = (ci == 2'd3 && !pal.four_color) ? 8'h00 : 8'hFF;
            end
        endcase
    end

    // Texel counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= pal.cpal[ci][0];
            green_reg <= pal.cpal[ci][1];
            blue_reg  <= pal.cpal[ci][2];
            alpha_reg <= alpha_next;
            index_reg <= cnt_reg;
            last_reg  <= (cnt_reg == dxt_pkg::LAST_TEXEL);
        end
    end

    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign alpha       = alpha_reg;
    assign texel_index = index_reg;
    assign last_texel  = last_reg;

    // A partly emitted block must still be held
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> pal_valid)
        else $error("texel counter mid-block without a held palette");

    // Retiring a block restarts the texel walk
    assert property (@(posedge clk) disable iff (!rst_n)
        pal_done |=> (cnt_reg == '0))
        else $error("texel counter not at zero after block retire");

    // Last flag only on the final texel of a block
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (index_reg == dxt_pkg::LAST_TEXEL))
        else $error("last flag on a texel other than the sixteenth");

endmodule
